// ----- src/aspt_pkg.sv -----
// aspt_pkg: shared types and constants for the allocation site pretenuring table
// no dependencies
package aspt_pkg;

  localparam int unsigned ThrW   = 17;
  localparam int unsigned MinW   = 32;
  localparam int unsigned IvW    = 16;
  localparam int unsigned TotalW = 38;
  localparam int unsigned CfgW   = 32;

  localparam logic [ThrW-1:0] ThrReset = 17'd52429;
  localparam logic [MinW-1:0] MinReset = 32'd100;
  localparam logic [IvW-1:0]  IvReset  = 16'd10;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_SURVIVE = 3'd1,
    OP_UPDATE  = 3'd2,
    OP_QUERY   = 3'd3,
    OP_SUMMARY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_SAMP  = 2'd1,
    CFG_DECAY     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,     // walk entries, issue the read of the current entry
    S_SCAN_CHK, // registered read data available
    S_MUL,      // threshold product
    S_DECIDE,   // compare and write mark
    S_WRITE,    // write back a single entry
    S_DECAY_RD,
    S_DECAY_WR,
    S_DONE
  } state_e;

endpackage

// ----- src/aspt_ram.sv -----
// aspt_ram: generic single-port write, single-port read ram, registered read
// no dependencies
module aspt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/alloc_site_pretenure_table.sv -----
// alloc_site_pretenure_table: one transaction at a time.
// alloc, survive, query: key search over the entries (one ram port), stopping at a hit, then a write-back state.
// update: scan marks every entry that meets min samples; on a halving, a further pass halves both counters.
// summary: a full scan of the entries, unused opcodes go straight to done; next transaction once the result is taken.
// reset clears valid bits, the decay phase and config; ram contents stay undefined.
module alloc_site_pretenure_table
  import aspt_pkg::*;
#(
  parameter int unsigned SITES      = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // opcode[2:0], site_id[66:3], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,  // status, pretenure_flag, tracked_sites,
                                      // pretenured_sites, total_allocations, zero pad
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int unsigned CntW = $clog2(SITES + 1);
  localparam int unsigned RamW = 64 + 2 * COUNT_BITS + 1;
  localparam int unsigned LhsW = COUNT_BITS + 16;
  localparam int unsigned RhsW = COUNT_BITS + ThrW;
  localparam int unsigned CmpW = (LhsW > RhsW) ? LhsW : RhsW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [TotalW-1:0]     TotalMax = '1;

  // config
  logic [ThrW-1:0] thr_q;
  logic [MinW-1:0] min_q;
  logic [IvW-1:0]  iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      min_q <= MinReset;
      iv_q  <= IvReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i[ThrW-1:0];
        CFG_MIN_SAMP:  min_q <= cfg_data_i[MinW-1:0];
        CFG_DECAY:     iv_q  <= cfg_data_i[IvW-1:0];
        default: ;
      endcase
    end
  end

  // entry ram: {mark, survive, alloc, key}
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [RamW-1:0] wdata, rdata;

  aspt_ram #(.Width(RamW), .Depth(SITES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [63:0]             r_key;
  logic [COUNT_BITS-1:0]   r_alloc, r_surv;
  logic                    r_mark;
  assign r_key   = rdata[63:0];
  assign r_alloc = rdata[64 +: COUNT_BITS];
  assign r_surv  = rdata[64 + COUNT_BITS +: COUNT_BITS];
  assign r_mark  = rdata[RamW-1];

  state_e state_q, state_d;
  logic [SITES-1:0]      valid_q, valid_d;
  logic [IvW-1:0]        phase_q, phase_d;
  op_e                   op_q, op_d;
  logic [63:0]           key_q, key_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic                  found_q, found_d;
  logic [IdxW-1:0]       hit_q, hit_d;
  logic                  free_q, free_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic [RamW-1:0]       ent_q, ent_d;
  logic [RhsW-1:0]       prod_q, prod_d;
  logic                  decay_q, decay_d;
  logic [1:0]            status_q, status_d;
  logic                  flag_q, flag_d;
  logic [CntW-1:0]       trk_q, trk_d, mrk_q, mrk_d;
  logic [TotalW-1:0]     tot_q, tot_d;
  logic                  ovalid_q, ovalid_d;

  logic [2:0]  in_op;
  logic [IdxW-1:0] cur;
  logic        last;
  logic [TotalW:0] sum;
  logic [CmpW-1:0] lhs, rhs;
  logic [IvW-1:0]  ivf, ph1;

  assign in_op = s_axis_tdata[2:0];
  assign cur   = idx_q[IdxW-1:0];
  assign last  = (idx_q == CntW'(SITES - 1));
  assign sum   = {1'b0, tot_q} + (TotalW+1)'(r_alloc);
  assign lhs   = CmpW'({ent_q[64 + COUNT_BITS +: COUNT_BITS], 16'd0});
  assign rhs   = CmpW'(prod_q);
  assign ivf   = (iv_q == '0) ? IvW'(1) : iv_q;
  assign ph1   = phase_q + IvW'(1);

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;

  always_comb begin
    state_d = state_q; valid_d = valid_q; phase_d = phase_q; op_d = op_q;
    key_d = key_q; idx_d = idx_q; found_d = found_q; hit_d = hit_q;
    free_d = free_q; free_idx_d = free_idx_q; ent_d = ent_q; prod_d = prod_q;
    decay_d = decay_q; status_d = status_q; flag_d = flag_q; trk_d = trk_q;
    mrk_d = mrk_q; tot_d = tot_q; ovalid_d = ovalid_q;
    we = 1'b0; waddr = cur; wdata = ent_q; raddr = cur;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          op_d = op_e'(in_op); key_d = s_axis_tdata[66:3];
          idx_d = '0; found_d = 1'b0; free_d = 1'b0;
          status_d = ST_OK; flag_d = 1'b0; trk_d = '0; mrk_d = '0; tot_d = '0;
          if (in_op == OP_UPDATE) begin
            phase_d = (ph1 >= ivf || ph1 == '0) ? '0 : ph1;
            decay_d = (ph1 >= ivf || ph1 == '0);
          end
          case (in_op)
            OP_ALLOC, OP_SURVIVE, OP_QUERY, OP_UPDATE, OP_SUMMARY: state_d = S_SCAN;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        raddr = cur;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        ent_d = rdata;
        state_d = S_SCAN;
        if (last) idx_d = idx_q; else idx_d = idx_q + CntW'(1);
        unique case (op_q)
          OP_SUMMARY: begin
            if (valid_q[cur]) begin
              trk_d = trk_q + CntW'(1);
              mrk_d = mrk_q + CntW'(r_mark);
              tot_d = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
            end
            if (last) state_d = S_DONE;
          end
          OP_UPDATE: begin
            if (valid_q[cur] && MinW'(r_alloc) >= min_q) begin
              state_d = S_MUL;
              idx_d = idx_q;
            end else if (last) begin
              idx_d = '0;
              state_d = decay_q ? S_DECAY_RD : S_DONE;
            end
          end
          default: begin
            if (!valid_q[cur] && !free_q) begin
              free_d = 1'b1; free_idx_d = cur;
            end
            if (valid_q[cur] && r_key == key_q) begin
              found_d = 1'b1; hit_d = cur; state_d = S_WRITE;
            end else if (last) begin
              state_d = S_WRITE;
            end
          end
        endcase
      end
      S_MUL: begin
        prod_d = RhsW'(ent_q[64 +: COUNT_BITS]) * RhsW'(thr_q);
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        we = 1'b1; waddr = cur;
        wdata = ent_q;
        // survived * 65536 >= threshold * allocs
        if (ent_q[64 +: COUNT_BITS] == '0) wdata[RamW-1] = (thr_q == '0);
        else wdata[RamW-1] = (lhs >= rhs);
        if (last) begin
          idx_d = '0;
          state_d = decay_q ? S_DECAY_RD : S_DONE;
        end else begin
          idx_d = idx_q + CntW'(1);
          state_d = S_SCAN;
        end
      end
      S_WRITE: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_ALLOC: begin
            if (found_q) begin
              we = 1'b1; waddr = hit_q; wdata = ent_q;
              if (ent_q[64 +: COUNT_BITS] != CountMax)
                wdata[64 +: COUNT_BITS] = ent_q[64 +: COUNT_BITS] + COUNT_BITS'(1);
            end else if (free_q) begin
              we = 1'b1; waddr = free_idx_q;
              wdata = {1'b0, {COUNT_BITS{1'b0}}, COUNT_BITS'(1), key_q};
              valid_d[free_idx_q] = 1'b1;
            end else status_d = ST_FULL;
          end
          OP_SURVIVE: begin
            if (found_q) begin
              we = 1'b1; waddr = hit_q; wdata = ent_q;
              if (ent_q[64 + COUNT_BITS +: COUNT_BITS] != CountMax)
                wdata[64 + COUNT_BITS +: COUNT_BITS] =
                  ent_q[64 + COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
            end else status_d = ST_NOT_FOUND;
          end
          default: begin
            if (found_q) flag_d = ent_q[RamW-1];
            else status_d = ST_NOT_FOUND;
          end
        endcase
      end
      S_DECAY_RD: begin
        raddr = cur;
        state_d = S_DECAY_WR;
      end
      S_DECAY_WR: begin
        we = 1'b1; waddr = cur;
        wdata = {r_mark, 1'b0, r_surv[COUNT_BITS-1:1], 1'b0,
                 r_alloc[COUNT_BITS-1:1], r_key};
        if (last) state_d = S_DONE;
        else begin
          idx_d = idx_q + CntW'(1);
          state_d = S_DECAY_RD;
        end
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      phase_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      phase_q <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; idx_q <= idx_d; found_q <= found_d;
    hit_q <= hit_d; free_q <= free_d; free_idx_q <= free_idx_d; ent_q <= ent_d;
    prod_q <= prod_d; decay_q <= decay_d; status_q <= status_d; flag_q <= flag_d;
    trk_q <= trk_d; mrk_q <= mrk_d; tot_q <= tot_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {1'b0, tot_q, 7'(mrk_q), 7'(trk_q), flag_q, status_q};

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("overlap");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");

endmodule

// ----- tb/alloc_site_pretenure_table_test.sv -----
// alloc_site_pretenure_table_test: stream-driven check of the pretenuring table
// against an in-bench model of the site table; depends on aspt_pkg and the dut
`timescale 1ns / 1ps

module alloc_site_pretenure_table_test;
  import aspt_pkg::*;

  localparam int NSITE = 64;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [37:0] TOT_MAX = {38{1'b1}};

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] site;
  } req_t;

  // lowest field last, so the cast matches the tdata packing
  typedef struct packed {
    logic [37:0] total;
    logic [6:0]  marked;
    logic [6:0]  tracked;
    logic        flag;
    logic [1:0]  status;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_THRESHOLD;
  logic [CfgW-1:0] cfg_data_i = '0;

  alloc_site_pretenure_table u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // table model
  logic [16:0] thr;
  logic [31:0] min_samp;
  logic [15:0] decay_iv;
  logic [63:0] key_q [NSITE];
  logic        valid_q [NSITE];
  logic [31:0] allocs_q [NSITE];
  logic [31:0] survs_q [NSITE];
  logic        mark_q [NSITE];
  logic [15:0] phase_q;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_sent = 0;
  bit   in_taken = 1'b0;

  function automatic int lookup_site(logic [63:0] k);
    for (int i = 0; i < NSITE; i++)
      if (valid_q[i] && key_q[i] == k) return i;
    return -1;
  endfunction

  function automatic bit survival_mark(logic [31:0] a, logic [31:0] s);
    logic [63:0] lhs, rhs;
    if (a == 0) return thr == 0;
    lhs = {16'd0, s, 16'd0};
    rhs = 64'(a) * 64'(thr);
    return lhs >= rhs;
  endfunction

  function automatic rsp_t table_step(req_t r);
    rsp_t o;
    int idx;
    logic [15:0] iv;
    o = '0;
    case (r.op)
      OP_ALLOC: begin
        idx = lookup_site(r.site);
        if (idx >= 0) begin
          if (allocs_q[idx] != CNT_MAX) allocs_q[idx]++;
        end else begin
          idx = -1;
          for (int i = 0; i < NSITE; i++)
            if (!valid_q[i]) begin idx = i; break; end
          if (idx >= 0) begin
            valid_q[idx] = 1'b1; key_q[idx] = r.site; allocs_q[idx] = 1;
            survs_q[idx] = 0; mark_q[idx] = 1'b0;
          end else o.status = ST_FULL;
        end
      end
      OP_SURVIVE: begin
        idx = lookup_site(r.site);
        if (idx >= 0) begin
          if (survs_q[idx] != CNT_MAX) survs_q[idx]++;
        end else o.status = ST_NOT_FOUND;
      end
      OP_UPDATE: begin
        iv = (decay_iv == 0) ? 16'd1 : decay_iv;
        for (int i = 0; i < NSITE; i++)
          if (valid_q[i] && allocs_q[i] >= min_samp)
            mark_q[i] = survival_mark(allocs_q[i], survs_q[i]);
        phase_q = phase_q + 16'd1;
        if (phase_q >= iv || phase_q == 0) begin
          phase_q = '0;
          for (int i = 0; i < NSITE; i++) begin
            allocs_q[i] = allocs_q[i] >> 1;
            survs_q[i] = survs_q[i] >> 1;
          end
        end
      end
      OP_QUERY: begin
        idx = lookup_site(r.site);
        if (idx >= 0) o.flag = mark_q[idx];
        else o.status = ST_NOT_FOUND;
      end
      OP_SUMMARY: begin
        for (int i = 0; i < NSITE; i++)
          if (valid_q[i]) begin
            o.tracked++;
            if (mark_q[i]) o.marked++;
            if (38'(allocs_q[i]) > TOT_MAX - o.total) o.total = TOT_MAX;
            else o.total += 38'(allocs_q[i]);
          end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver: bursts with random gaps, hold-off flag for the drain pause
  int  gap_left = 0;
  int  burst_left = 0;
  bit  hold_off = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
        // keep current transaction
      end else begin
        in_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_off) begin
          s_axis_tdata <= {5'd0, pending_reqs[0].site, pending_reqs[0].op};
          s_axis_tvalid <= 1'b1;
          void'(pending_reqs.pop_front());
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // the prediction is taken at acceptance, so model state tracks the dut order
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_rsps.push_back(table_step(req_t'({s_axis_tdata[2:0], s_axis_tdata[66:3]})));
      n_sent++;
      in_taken = 1'b1;
    end
  end

  // receiver stall pattern
  int stall_ctr = 0;
  always @(negedge clk_i) begin
    stall_ctr++;
    case ((stall_ctr / 64) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_ctr % 7) < 3;
      default: m_axis_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = rsp_t'(m_axis_tdata[54:0]);
      if (expected_rsps.size() == 0) report_mismatch("unexpected result", 64'(got), 64'd0);
      else begin
        want = expected_rsps.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.flag !== want.flag)
          report_mismatch("pretenure_flag", 64'(got.flag), 64'(want.flag));
        if (got.tracked !== want.tracked)
          report_mismatch("tracked_sites", 64'(got.tracked), 64'(want.tracked));
        if (got.marked !== want.marked)
          report_mismatch("pretenured_sites", 64'(got.marked), 64'(want.marked));
        if (got.total !== want.total)
          report_mismatch("total_allocations", 64'(got.total), 64'(want.total));
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr = val[16:0];
      CFG_MIN_SAMP: min_samp = val;
      default: decay_iv = val[15:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // well-formed site ids, mostly from a small pool, so hits and repeats are common
  logic [63:0] site_pool[16];
  function automatic logic [63:0] pick_site();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return site_pool[$urandom_range(0, 15)];
  endfunction

  task automatic push(op_e op, logic [63:0] s);
    req_t r;
    r.op = op; r.site = s;
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(int n, int alloc_w);
    int k;
    req_t r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < alloc_w) push(OP_ALLOC, pick_site());
      else if (k < alloc_w + 25) push(OP_SURVIVE, pick_site());
      else if (k < alloc_w + 35) push(OP_UPDATE, {$urandom, $urandom});
      else if (k < alloc_w + 45) push(OP_QUERY, pick_site());
      else if (k < 98) push(OP_SUMMARY, {$urandom, $urandom});
      else begin
        r.op = 3'($urandom_range(5, 7)); r.site = {$urandom, $urandom};
        pending_reqs.push_back(r);
      end
    end
  endtask

  initial begin
    thr = ThrReset; min_samp = MinReset; decay_iv = IvReset; phase_q = '0;
    for (int i = 0; i < NSITE; i++) begin
      valid_q[i] = 0; key_q[i] = 0; allocs_q[i] = 0; survs_q[i] = 0; mark_q[i] = 0;
    end
    for (int i = 0; i < 16; i++) site_pool[i] = {$urandom, $urandom};
    site_pool[0] = '0; site_pool[1] = '1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every op, unknown sites, unused opcodes
    push(OP_QUERY, 64'd0);
    push(OP_SURVIVE, '1);
    push(OP_ALLOC, 64'd0);
    push(OP_ALLOC, '1);
    push(OP_ALLOC, '1);
    push(OP_SURVIVE, '1);
    push(OP_SURVIVE, 64'd0);
    push(OP_QUERY, '1);
    push(OP_SUMMARY, '1);
    push(OP_UPDATE, 64'h5555_5555_5555_5555);
    pending_reqs.push_back(req_t'({3'd5, 64'hAAAA_AAAA_AAAA_AAAA}));
    pending_reqs.push_back(req_t'({3'd6, 64'd1}));
    pending_reqs.push_back(req_t'({3'd7, '1}));
    push(OP_QUERY, 64'h8000_0000_0000_0000);
    push(OP_SUMMARY, 64'd0);
    wait_idle();

    // zero min samples and zero threshold: every site marked, halving each update
    write_reg(CFG_MIN_SAMP, 32'd0);
    write_reg(CFG_THRESHOLD, 32'd0);
    write_reg(CFG_DECAY, 32'd0);
    push(OP_UPDATE, 64'd0); push(OP_QUERY, 64'd0); push(OP_SUMMARY, 64'd0);
    push(OP_UPDATE, 64'd0); push(OP_SUMMARY, 64'd0);
    wait_idle();

    // fill the table beyond capacity to hit the full case
    write_reg(CFG_THRESHOLD, 32'd65536);
    write_reg(CFG_MIN_SAMP, 32'd1);
    write_reg(CFG_DECAY, 32'd65535);
    for (int i = 0; i < 66; i++) push(OP_ALLOC, 64'(i) << 56 | 64'(i));
    push(OP_SUMMARY, 64'd0);
    random_phase(60, 30);
    wait_idle();

    // reset threshold and decay, then random mixes at several settings
    write_reg(CFG_THRESHOLD, 32'd52429);
    write_reg(CFG_MIN_SAMP, 32'd4);
    write_reg(CFG_DECAY, 32'd10);
    random_phase(140, 35);
    wait_idle();
    write_reg(CFG_THRESHOLD, 32'd32768);
    write_reg(CFG_MIN_SAMP, 32'hFFFF_FFFF);
    write_reg(CFG_DECAY, 32'd3);
    random_phase(100, 35);
    wait_idle();
    write_reg(CFG_THRESHOLD, $urandom_range(0, 65536));
    write_reg(CFG_MIN_SAMP, $urandom_range(0, 8));
    write_reg(CFG_DECAY, $urandom_range(1, 6));
    random_phase(160, 30);
    wait_idle();

    $display("ran %0d transactions, %0d results checked, full table and decay included",
             n_sent, n_checked);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
